[rtl/core/ltq_pkg.sv]
`default_nettype none

package ltq_pkg;

    localparam logic [1:0] TERM_NORMAL   = 2'd0;
    localparam logic [1:0] TERM_BANG     = 2'd1;
    localparam logic [1:0] TERM_NO_MINUS = 2'd2;

    localparam logic [8:0] COUNT_MAX = 9'd511;

    localparam logic [7:0] CH_BANG   = 8'h21;
    localparam logic [7:0] CH_QUOTE  = 8'h22;
    localparam logic [7:0] CH_BSLASH = 8'h5C;
    localparam logic [7:0] CH_LF     = 8'h0A;
    localparam logic [7:0] CH_TAB    = 8'h09;
    localparam logic [7:0] CH_SPACE  = 8'h20;
    localparam logic [7:0] CH_MINUS  = 8'h2D;
    localparam logic [7:0] CH_LOW_A  = 8'h61;
    localparam logic [7:0] CH_LOW_Z  = 8'h7A;
    localparam logic [7:0] CASE_DIFF = 8'h20;

    typedef struct packed {
        logic       in_word;
        logic       quoted;
        logic       prev_backslash;
        logic       comment_seen;
        logic [8:0] token_count;
    } line_state_t;

    typedef struct packed {
        logic       char_valid;
        logic [7:0] char_out;
        logic       new_token;
        logic [8:0] token_number;
        logic       line_done;
        logic       over_limit;
    } tok_result_t;

endpackage

`default_nettype wire

[rtl/core/ltq_step.sv]
`default_nettype none

module ltq_step #(
    parameter int TOKEN_LIMIT = 280
) (
    input  wire logic [1:0]          term_mode,
    input  wire logic [7:0]          char_in,
    input  wire logic                last_in_line,
    input  wire ltq_pkg::line_state_t state,
    output ltq_pkg::line_state_t     state_next,
    output ltq_pkg::tok_result_t     result
);

    localparam logic [8:0] LIMIT = 9'(TOKEN_LIMIT);

    logic       is_term;
    logic       valid;
    logic       newt;
    logic [7:0] oc;
    logic [8:0] count_next;
    ltq_pkg::line_state_t st;

    always_comb
    begin
        is_term = 1'b0;
        if (char_in == ltq_pkg::CH_BANG)
        begin
            is_term = 1'b1;
        end
        else if (term_mode != ltq_pkg::TERM_BANG)
        begin
            if (char_in == ltq_pkg::CH_MINUS)
            begin
                is_term = (term_mode != ltq_pkg::TERM_NO_MINUS);
            end
            else
            begin
                case (char_in)
                    8'h2C, 8'h2B, 8'h2A, 8'h29, 8'h28, 8'h3C, 8'h3E, 8'h3D,
                    8'h2F, 8'h5E, 8'h40: is_term = 1'b1;
                    default: is_term = 1'b0;
                endcase
            end
        end
    end

    always_comb
    begin
        st    = state;
        valid = 1'b0;
        newt  = 1'b0;
        oc    = 8'h00;
        if (!state.comment_seen && !(last_in_line && char_in == ltq_pkg::CH_LF))
        begin
            if (state.quoted)
            begin
                valid = 1'b1;
                oc    = char_in;
                if (char_in == ltq_pkg::CH_QUOTE && !state.prev_backslash)
                begin
                    st.quoted = 1'b0;
                end
                st.prev_backslash = (char_in == ltq_pkg::CH_BSLASH);
            end
            else if (char_in == ltq_pkg::CH_SPACE || char_in == ltq_pkg::CH_TAB)
            begin
                st.in_word = 1'b0;
            end
            else if (char_in == ltq_pkg::CH_BANG)
            begin
                st.comment_seen = 1'b1;
                st.in_word      = 1'b0;
            end
            else if (is_term)
            begin
                valid      = 1'b1;
                newt       = 1'b1;
                oc         = char_in;
                st.in_word = 1'b0;
            end
            else
            begin
                valid = 1'b1;
                if (char_in >= ltq_pkg::CH_LOW_A && char_in <= ltq_pkg::CH_LOW_Z)
                begin
                    oc = char_in - ltq_pkg::CASE_DIFF;
                end
                else
                begin
                    oc = char_in;
                end
                newt       = !state.in_word;
                st.in_word = 1'b1;
                if (char_in == ltq_pkg::CH_QUOTE)
                begin
                    st.quoted = 1'b1;
                end
                st.prev_backslash = (char_in == ltq_pkg::CH_BSLASH);
            end
        end

        count_next = state.token_count;
        if (newt && state.token_count < ltq_pkg::COUNT_MAX)
        begin
            count_next = state.token_count + 9'd1;
        end
        st.token_count = count_next;

        result.char_valid   = valid;
        result.char_out     = oc;
        result.new_token    = newt;
        result.token_number = count_next;
        result.line_done    = last_in_line;
        result.over_limit   = (count_next > LIMIT);

        if (last_in_line)
        begin
            state_next = '0;
        end
        else
        begin
            state_next = st;
        end
    end

endmodule

`default_nettype wire

[rtl/core/line_tokenizer_with_quotes.sv]
// An accepted item is held in the input register, then the tokenizer step fills the output
// register, which drives the master side.
// Throughput: one item per cycle. With m_axis_tready low both registers fill and the
// input stalls; s_axis_tready then follows m_axis_tready in the same cycle.
// Reset (rst_n low, asynchronous): line state, pipeline valids and term_mode clear to 0.
`default_nettype none

module line_tokenizer_with_quotes #(
    parameter int TOKEN_LIMIT = 280
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        cfg_we,
    input  wire logic [1:0]  cfg_wdata,
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    input  wire logic [7:0]  s_axis_tdata,  // [7:0] char_in
    input  wire logic        s_axis_tlast,  // last_in_line
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    output logic [23:0]      m_axis_tdata,  // [7:0] char_out, [16:8] token_number,
                                            // [17] over_limit, [23:18] zero
    output logic [1:0]       m_axis_tuser,  // [0] char_valid, [1] new_token
    output logic             m_axis_tlast   // line_done
);

    logic [1:0]           term_mode_reg;
    logic                 in_valid_reg;
    logic [7:0]           in_char_reg;
    logic                 in_last_reg;
    ltq_pkg::line_state_t state_reg;
    ltq_pkg::line_state_t state_next;
    ltq_pkg::tok_result_t step_result;
    logic                 out_valid_reg;
    ltq_pkg::tok_result_t out_result_reg;
    logic                 out_free;
    logic                 advance;

    assign out_free      = !out_valid_reg || m_axis_tready;
    assign advance       = in_valid_reg && out_free;
    assign s_axis_tready = !in_valid_reg || advance;

    ltq_step #(
        .TOKEN_LIMIT(TOKEN_LIMIT)
    ) u_step (
        .term_mode   (term_mode_reg),
        .char_in     (in_char_reg),
        .last_in_line(in_last_reg),
        .state       (state_reg),
        .state_next  (state_next),
        .result      (step_result)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            term_mode_reg <= ltq_pkg::TERM_NORMAL;
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            state_reg     <= '0;
        end
        else
        begin
            if (cfg_we)
            begin
                term_mode_reg <= cfg_wdata;
            end
            if (s_axis_tready)
            begin
                in_valid_reg <= s_axis_tvalid;
            end
            if (advance)
            begin
                state_reg <= state_next;
            end
            if (out_free)
            begin
                out_valid_reg <= in_valid_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_axis_tvalid && s_axis_tready)
        begin
            in_char_reg <= s_axis_tdata;
            in_last_reg <= s_axis_tlast;
        end
        if (advance)
        begin
            out_result_reg <= step_result;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {6'd0, out_result_reg.over_limit, out_result_reg.token_number,
                            out_result_reg.char_out};
    assign m_axis_tuser  = {out_result_reg.new_token, out_result_reg.char_valid};
    assign m_axis_tlast  = out_result_reg.line_done;

endmodule

`default_nettype wire
